>>> rtl/core/ircp_pkg.sv
// Shared types and constants of the row and column projection block.
// Used by ircp_lane, ircp_merge and image_row_column_projection_top.
`timescale 1ns / 1ps

package ircp_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int LANES        = 4;
    localparam int FIELD_LANES  = 4;
    localparam int ACTIVE_LANES = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;

    localparam int SAMPLE_W = 32;
    localparam int BIN_W    = 16;
    localparam int ROW_W    = 16;
    localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    localparam int OUT_DEPTH = 8;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_COLUMN = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_COMBINE_MODE = 3'd0;
    localparam logic [2:0] REG_SIGNED       = 3'd1;
    localparam logic [2:0] REG_BANDS        = 3'd2;
    localparam logic [2:0] REG_WIDTH        = 3'd3;
    localparam logic [2:0] REG_HEIGHT       = 3'd4;

    // Combine modes; the unused code acts as a sum.
    localparam logic [1:0] MODE_SUM = 2'd0;
    localparam logic [1:0] MODE_MAX = 2'd1;
    localparam logic [1:0] MODE_MIN = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic       signed_samples;
    } lane_cfg_t;

    // Pixel in the registered pipeline stage, seen by the output merge.
    typedef struct packed {
        logic             valid;
        logic             row_end;
        logic             last_row;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } stage_info_t;

    typedef struct packed {
        logic                                   frame_done;
        logic [FIELD_LANES-1:0][SAMPLE_W-1:0]   values;
        logic [BIN_W-1:0]                       bin_index;
        logic                                   result_kind;
    } out_word_t;

endpackage

>>> rtl/core/ircp_lane.sv
// One band lane: column store, row accumulator and the combine unit.
// Depends on ircp_pkg for widths and the lane configuration type.
`timescale 1ns / 1ps

module ircp_lane (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ircp_pkg::lane_cfg_t             cfg,
    input  logic                            in_valid,
    input  logic                            in_enable,
    input  logic                            in_first_row,
    input  logic                            in_first_col,
    input  logic [ircp_pkg::COL_W-1:0]      in_slot,
    input  logic [ircp_pkg::SAMPLE_W-1:0]   in_sample,
    output logic [ircp_pkg::SAMPLE_W-1:0]   col_value,
    output logic [ircp_pkg::SAMPLE_W-1:0]   row_value
);
    import ircp_pkg::*;

    localparam logic [SAMPLE_W-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic [SAMPLE_W-1:0] col_mem [MAX_WIDTH];

    logic                valid_reg;
    logic                enable_reg;
    logic                first_row_reg;
    logic                first_col_reg;
    logic [COL_W-1:0]    slot_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                fwd_reg;
    logic [SAMPLE_W-1:0] wr_data_reg;
    logic [SAMPLE_W-1:0] row_acc_reg;

    logic [SAMPLE_W-1:0] col_old;
    logic [SAMPLE_W-1:0] col_next;
    logic [SAMPLE_W-1:0] row_next;
    logic                wr_en;

    function automatic logic [SAMPLE_W-1:0] combine(input logic [SAMPLE_W-1:0] acc,
                                                    input logic [SAMPLE_W-1:0] s,
                                                    input lane_cfg_t c);
        logic [SAMPLE_W-1:0] ka;
        logic [SAMPLE_W-1:0] ks;
        logic [SAMPLE_W-1:0] res;
        begin
            ka = c.signed_samples ? (acc ^ SIGN_FLIP) : acc;
            ks = c.signed_samples ? (s ^ SIGN_FLIP) : s;
            case (c.mode)
                MODE_MAX: res = (ks > ka) ? s : acc;
                MODE_MIN: res = (ks < ka) ? s : acc;
                default:  res = acc + s;
            endcase
            return res;
        end
    endfunction

    assign wr_en = valid_reg & enable_reg;

    // A read issued while the previous pixel writes the same column returns
    // stale data, so the value written in that cycle is used instead.
    assign col_old  = fwd_reg ? wr_data_reg : rd_data_reg;
    assign col_next = first_row_reg ? sample_reg : combine(col_old, sample_reg, cfg);
    assign row_next = first_col_reg ? sample_reg : combine(row_acc_reg, sample_reg, cfg);

    assign col_value = enable_reg ? col_next : '0;
    assign row_value = enable_reg ? row_next : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            col_mem[slot_reg] <= col_next;
        end
        if (in_valid)
        begin
            rd_data_reg <= col_mem[in_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            fwd_reg     <= 1'b0;
            row_acc_reg <= '0;
        end
        else
        begin
            valid_reg <= in_valid;
            if (in_valid)
            begin
                fwd_reg <= wr_en && (slot_reg == in_slot);
            end
            if (wr_en)
            begin
                row_acc_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            enable_reg    <= in_enable;
            first_row_reg <= in_first_row;
            first_col_reg <= in_first_col;
            slot_reg      <= in_slot;
            sample_reg    <= in_sample;
        end
        if (wr_en)
        begin
            wr_data_reg <= col_next;
        end
    end

endmodule

>>> rtl/core/ircp_merge.sv
// Output merge: gathers the lane results of a pixel into row and column
// words and queues them for the output stream. Depends on ircp_pkg.
`timescale 1ns / 1ps

module ircp_merge (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  ircp_pkg::stage_info_t                              info,
    input  logic [ircp_pkg::ACTIVE_LANES-1:0][ircp_pkg::SAMPLE_W-1:0] row_vals,
    input  logic [ircp_pkg::ACTIVE_LANES-1:0][ircp_pkg::SAMPLE_W-1:0] col_vals,
    output logic                                               room,
    output logic                                               out_valid,
    input  logic                                               out_ready,
    output ircp_pkg::out_word_t                                out_word
);
    import ircp_pkg::*;

    out_word_t queue [OUT_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic [FIELD_LANES-1:0][SAMPLE_W-1:0] row_field;
    logic [FIELD_LANES-1:0][SAMPLE_W-1:0] col_field;
    out_word_t row_word;
    out_word_t col_word;
    logic [1:0] n_push;
    logic       pop;

    for (genvar l = 0; l < FIELD_LANES; l++)
    begin : g_field
        if (l < ACTIVE_LANES)
        begin : g_used
            assign row_field[l] = row_vals[l];
            assign col_field[l] = col_vals[l];
        end
        else
        begin : g_unused
            assign row_field[l] = '0;
            assign col_field[l] = '0;
        end
    end

    always_comb
    begin
        row_word.result_kind = KIND_ROW;
        row_word.bin_index   = BIN_W'(info.row);
        row_word.values      = row_field;
        row_word.frame_done  = 1'b0;
        col_word.result_kind = KIND_COLUMN;
        col_word.bin_index   = BIN_W'(info.col);
        col_word.values      = col_field;
        col_word.frame_done  = info.row_end;
    end

    assign n_push = info.valid ? (2'(info.row_end) + 2'(info.last_row)) : 2'd0;
    assign pop    = out_valid & out_ready;

    // Leave space for the pixel in flight and one more that may enter now.
    assign room = ((CNT_W+1)'(cnt_reg) + (CNT_W+1)'(n_push)) <= (CNT_W+1)'(OUT_DEPTH - 2);

    assign out_valid = (cnt_reg != '0);
    assign out_word  = queue[rd_ptr_reg];
    assign cnt_next  = cnt_reg + CNT_W'(n_push) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (info.valid && info.row_end)
        begin
            queue[wr_ptr_reg] <= row_word;
            if (info.last_row)
            begin
                queue[wr_ptr_reg + 1'b1] <= col_word;
            end
        end
        else if (info.valid && info.last_row)
        begin
            queue[wr_ptr_reg] <= col_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_push);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        info.valid |-> ((CNT_W+1)'(cnt_reg) + (CNT_W+1)'(n_push) <= (CNT_W+1)'(OUT_DEPTH)))
        else $error("output queue overflow");

    a_done_on_column: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.frame_done) |-> (out_word.result_kind == KIND_COLUMN))
        else $error("frame end marked on a row result");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == OUT_DEPTH) || (PTR_W'(cnt_reg) == PTR_W'(wr_ptr_reg - rd_ptr_reg)))
        else $error("queue count disagrees with pointers");

endmodule

>>> rtl/core/image_row_column_projection_top.sv
// Top level of the row and column projection block: configuration,
// raster position tracking, the band lanes and the output merge.
`timescale 1ns / 1ps

// The block accepts one pixel per clock while the output queue has room and
// answers each row with one row word at its last pixel, and each column with
// one column word per pixel of the frame's last row; words leave one per
// clock while m_tready is high, so the last pixel of a last row yields one
// extra word. The output queue absorbs it when the following rows are quieter;
// when every row is a last row (a height of one) the input backs off. A pixel
// is registered into the lanes and s1, then its words enter the output queue.
// Each lane keeps its column results in a 1024-entry memory with one read
// and one write port; a pixel that follows one in the same column gets the
// just-written value by forwarding. The column memory is not cleared after
// reset; every column is seeded by the frame's first row.
module image_row_column_projection_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // sample_a, sample_b, sample_c, sample_d
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // bin_index, value_a, value_b, value_c, value_d
    output logic [0:0]   m_tuser,   // result_kind
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import ircp_pkg::*;

    localparam int WIDTH_W = 11;

    logic [1:0]          mode_reg;
    logic                signed_reg;
    logic [2:0]          bands_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [ROW_W-1:0]    height_reg;

    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    stage_info_t         s1_reg;
    stage_info_t         s1_next;

    logic                accept;
    logic                room;
    logic [2:0]          lanes_eff;
    logic [WIDTH_W-1:0]  width_eff;
    logic [ROW_W-1:0]    height_eff;
    logic [COL_W-1:0]    last_col;
    logic                row_end;
    logic                last_row;
    lane_cfg_t           lane_cfg;
    out_word_t           head;

    logic [ACTIVE_LANES-1:0][SAMPLE_W-1:0] row_vals;
    logic [ACTIVE_LANES-1:0][SAMPLE_W-1:0] col_vals;

    assign cfg_ready = 1'b1;
    assign s_tready  = room;
    assign accept    = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            signed_reg <= 1'b0;
            bands_reg  <= 3'd1;
            width_reg  <= WIDTH_W'(1024);
            height_reg <= ROW_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COMBINE_MODE: mode_reg   <= cfg_data[1:0];
                REG_SIGNED:       signed_reg <= cfg_data[0];
                REG_BANDS:        bands_reg  <= cfg_data[2:0];
                REG_WIDTH:        width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_HEIGHT:       height_reg <= cfg_data[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (bands_reg == '0)
            lanes_eff = 3'd1;
        else if (int'(bands_reg) > ACTIVE_LANES)
            lanes_eff = 3'(ACTIVE_LANES);
        else
            lanes_eff = bands_reg;

        if (width_reg == '0)
            width_eff = WIDTH_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            width_eff = WIDTH_W'(MAX_WIDTH);
        else
            width_eff = width_reg;

        height_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
    end

    // A position at or past the last column or row closes it, which also
    // covers a geometry shrunk in the middle of a frame.
    assign last_col = COL_W'(width_eff - 1'b1);
    assign row_end  = (col_reg >= last_col);
    assign last_row = (row_reg >= height_eff - 1'b1);

    assign lane_cfg.mode           = mode_reg;
    assign lane_cfg.signed_samples = signed_reg;

    always_comb
    begin
        s1_next.valid    = accept;
        s1_next.row_end  = row_end;
        s1_next.last_row = last_row;
        s1_next.col      = col_reg;
        s1_next.row      = row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            s1_reg  <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
            if (accept)
            begin
                if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    for (genvar l = 0; l < ACTIVE_LANES; l++)
    begin : g_lane
        ircp_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .cfg          (lane_cfg),
            .in_valid     (accept),
            .in_enable    (l < int'(lanes_eff)),
            .in_first_row (row_reg == '0),
            .in_first_col (col_reg == '0),
            .in_slot      (col_reg),
            .in_sample    (s_tdata[l*SAMPLE_W +: SAMPLE_W]),
            .col_value    (col_vals[l]),
            .row_value    (row_vals[l])
        );
    end

    ircp_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .info      (s1_reg),
        .row_vals  (row_vals),
        .col_vals  (col_vals),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (head)
    );

    assign m_tdata  = {head.values[3], head.values[2], head.values[1], head.values[0],
                       head.bin_index};
    assign m_tuser  = head.result_kind;
    assign m_tlast  = head.frame_done;

endmodule
